@@ src/tpb_pkg.sv @@
// Shared types, constants and helpers of the tile palette builder.
// Used by tpb_color_conv, tpb_cell and tile_palette_builder_unit.
`default_nettype none

package tpb_pkg;

    localparam int COMP_W  = 8;
    localparam int KEY_W   = 24;
    localparam int CNT_W   = 7;
    localparam int SUM_W   = 14;
    localparam int IDX_W   = 4;
    localparam int DEPTH_W = 4;

    localparam logic [COMP_W-1:0]  COMP_MAX  = 8'hFF;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 4'd8;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 7'd127;
    localparam logic [SUM_W-1:0]   SUM_MAX   = 14'h3FFF;

    typedef enum logic {
        ST_PIXEL,
        ST_REPORT
    } t_state;

    typedef enum logic {
        KIND_PIXEL  = 1'b0,
        KIND_REPORT = 1'b1
    } t_kind;

    // One palette entry as held in a cell and passed down the chain
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum_y;
        logic [SUM_W-1:0] sum_u;
        logic [SUM_W-1:0] sum_v;
    } t_entry;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic clear;
        logic shift;
        logic update;
        logic alloc_en;
    } t_cell_ctl;

    // Top 'depth' bits of a component; depths above eight act as eight
    function automatic logic [COMP_W-1:0] f_depth_mask(input logic [DEPTH_W-1:0] depth);
        logic [DEPTH_W-1:0] d;
        d = (depth > DEPTH_MAX) ? DEPTH_MAX : depth;
        return ~(COMP_MAX >> d);
    endfunction

endpackage

`default_nettype wire

@@ src/tpb_color_conv.sv @@
// RGB to luma/chroma conversion of one pixel.
// Depends on tpb_pkg for component widths.
`default_nettype none

module tpb_color_conv
    import tpb_pkg::*;
(
    input  wire logic [COMP_W-1:0] i_red,
    input  wire logic [COMP_W-1:0] i_green,
    input  wire logic [COMP_W-1:0] i_blue,
    output logic      [COMP_W-1:0] o_y,
    output logic      [COMP_W-1:0] o_u,
    output logic      [COMP_W-1:0] o_v
);

    logic [COMP_W+1:0] w_luma_sum;
    logic [COMP_W:0]   w_u_sum;
    logic [COMP_W:0]   w_v_sum;

    assign w_luma_sum = {2'b00, i_red} + {1'b0, i_green, 1'b0} + {2'b00, i_blue};
    assign o_y        = w_luma_sum[COMP_W+1:2];

    // 255 - y is the bitwise complement of y
    assign w_u_sum = {1'b0, i_blue} + {1'b0, ~o_y};
    assign w_v_sum = {1'b0, i_red}  + {1'b0, ~o_y};
    assign o_u     = w_u_sum[COMP_W:1];
    assign o_v     = w_v_sum[COMP_W:1];

endmodule

`default_nettype wire

@@ src/tpb_cell.sv @@
// One palette entry cell: key compare, allocation, saturating accumulation, clear,
// and shift toward the chain head during the palette drain. Depends on tpb_pkg.
`default_nettype none

module tpb_cell
    import tpb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [KEY_W-1:0] i_mask,
    input  wire logic             i_prev_valid,
    input  wire logic             i_sel,
    input  wire logic             i_next_valid,
    input  wire t_entry           i_next,
    output logic                  o_valid,
    output logic                  o_hit,
    output t_entry                o_entry
);

    logic   r_valid;
    logic   n_valid;
    t_entry r_ent;
    t_entry n_ent;
    logic   w_alloc;

    function automatic logic [SUM_W-1:0] f_sat_add(input logic [SUM_W-1:0] a,
                                                   input logic [COMP_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // Valid cells form a prefix, so the first empty cell takes a new key
    assign w_alloc = i_ctl.alloc_en && !r_valid && i_prev_valid;
    assign o_hit   = r_valid && (((r_ent.key ^ i_key) & i_mask) == '0);
    assign o_valid = r_valid;
    assign o_entry = r_ent;

    always_comb begin
        n_valid = r_valid;
        n_ent   = r_ent;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift) begin
            n_valid = i_next_valid;
            n_ent   = i_next;
        end else if (w_alloc) begin
            n_valid     = 1'b1;
            n_ent.key   = i_key;
            n_ent.count = CNT_W'(1);
            n_ent.sum_y = SUM_W'(i_key[KEY_W-1 -: COMP_W]);
            n_ent.sum_u = SUM_W'(i_key[2*COMP_W-1 -: COMP_W]);
            n_ent.sum_v = SUM_W'(i_key[COMP_W-1:0]);
        end else if (i_ctl.update && i_sel) begin
            n_ent.count = (r_ent.count == CNT_MAX) ? CNT_MAX : r_ent.count + CNT_W'(1);
            n_ent.sum_y = f_sat_add(r_ent.sum_y, i_key[KEY_W-1 -: COMP_W]);
            n_ent.sum_u = f_sat_add(r_ent.sum_u, i_key[2*COMP_W-1 -: COMP_W]);
            n_ent.sum_v = f_sat_add(r_ent.sum_v, i_key[COMP_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

`default_nettype wire

@@ src/tile_palette_builder_unit.sv @@
// Tile palette builder: top level with pixel front stage, cell chain and control.
// Depends on tpb_pkg, tpb_color_conv and tpb_cell.
`default_nettype none

// Pixels enter one per clock while o_in_stall is low: each request is converted
// to a luma/chroma key in a front register, then matched against a chain of
// PALETTE_SIZE cells, each holding one palette entry, and its palette index is
// registered in the output register. A tile's last pixel, unless the palette
// overflowed, is followed by one report per used entry (up to PALETTE_SIZE), one
// a cycle while the output does not stall, as the cells shift their contents
// toward the head of the chain. During that drain the front register takes at
// most one further request and input requests then stall. An output stall holds
// the front stage. The chain is empty again once the drain ends, ready for the
// next tile.
module tile_palette_builder_unit
    import tpb_pkg::*;
#(
    parameter int PALETTE_SIZE = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [DEPTH_W-1:0] i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [COMP_W-1:0]  i_pixel_red,
    input  wire logic [COMP_W-1:0]  i_pixel_green,
    input  wire logic [COMP_W-1:0]  i_pixel_blue,
    input  wire logic               i_end_of_tile,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_item_kind,
    output logic      [IDX_W-1:0]   o_entry_index,
    output logic                    o_overflowed,
    output logic      [CNT_W-1:0]   o_pixel_count,
    output logic      [SUM_W-1:0]   o_sum_luma,
    output logic      [SUM_W-1:0]   o_sum_chroma_u,
    output logic      [SUM_W-1:0]   o_sum_chroma_v,
    output logic                    o_final_result
);

    // Configuration
    logic [DEPTH_W-1:0] r_depth;
    logic [COMP_W-1:0]  w_comp_mask;
    logic [KEY_W-1:0]   w_mask;

    // Front stage
    logic [COMP_W-1:0] w_y;
    logic [COMP_W-1:0] w_u;
    logic [COMP_W-1:0] w_v;
    logic              w_in_acc;
    logic              r_p_valid;
    logic              n_p_valid;
    logic [KEY_W-1:0]  r_p_key;
    logic              r_p_last;

    // Cell chain
    t_cell_ctl             w_ctl;
    logic [PALETTE_SIZE-1:0] w_valid;
    logic [PALETTE_SIZE-1:0] w_hit;
    logic [PALETTE_SIZE-1:0] w_first;
    logic [PALETTE_SIZE-1:0] w_alloc_vec;
    logic [PALETTE_SIZE-1:0] w_pick;
    t_entry                w_ent [PALETTE_SIZE];
    logic                  w_any_hit;
    logic                  w_full;
    logic                  w_ovf_new;
    logic [IDX_W-1:0]      w_idx;

    // Control
    t_state           r_state;
    t_state           n_state;
    logic             r_ovf;
    logic [IDX_W-1:0] r_rep_idx;
    logic             w_out_free;
    logic             w_proc;
    logic             w_rep_take;

    // Output register
    logic             r_o_valid;
    logic             n_o_valid;
    t_kind            r_o_kind;
    logic [IDX_W-1:0] r_o_idx;
    logic             r_o_ovf;
    logic [CNT_W-1:0] r_o_cnt;
    logic [SUM_W-1:0] r_o_sy;
    logic [SUM_W-1:0] r_o_su;
    logic [SUM_W-1:0] r_o_sv;
    logic             r_o_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= DEPTH_MAX;
        end else if (i_cfg_we) begin
            r_depth <= i_cfg_wdata;
        end
    end

    assign w_comp_mask = f_depth_mask(r_depth);
    assign w_mask      = {w_comp_mask, w_comp_mask, w_comp_mask};

    tpb_color_conv u_conv (
        .i_red   (i_pixel_red),
        .i_green (i_pixel_green),
        .i_blue  (i_pixel_blue),
        .o_y     (w_y),
        .o_u     (w_u),
        .o_v     (w_v)
    );

    assign o_in_stall = r_p_valid && !w_proc;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        n_p_valid = r_p_valid;
        if (w_in_acc) begin
            n_p_valid = 1'b1;
        end else if (w_proc) begin
            n_p_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_p_key  <= {w_y, w_u, w_v};
            r_p_last <= i_end_of_tile;
        end
    end

    genvar k;
    generate
        for (k = 0; k < PALETTE_SIZE; k++) begin : g_cell
            logic   w_prev_valid;
            logic   w_next_valid;
            t_entry w_next;

            if (k == 0) begin : g_head
                assign w_prev_valid = 1'b1;
            end else begin : g_body
                assign w_prev_valid = w_valid[k-1];
            end

            if (k == PALETTE_SIZE - 1) begin : g_tail
                assign w_next_valid = 1'b0;
                assign w_next       = '0;
            end else begin : g_inner
                assign w_next_valid = w_valid[k+1];
                assign w_next       = w_ent[k+1];
            end

            assign w_alloc_vec[k] = !w_valid[k] && w_prev_valid;

            tpb_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_key        (r_p_key),
                .i_mask       (w_mask),
                .i_prev_valid (w_prev_valid),
                .i_sel        (w_first[k]),
                .i_next_valid (w_next_valid),
                .i_next       (w_next),
                .o_valid      (w_valid[k]),
                .o_hit        (w_hit[k]),
                .o_entry      (w_ent[k])
            );
        end
    endgenerate

    // Earliest entry wins when a depth change makes several keys match
    assign w_first   = w_hit & (~w_hit + {{(PALETTE_SIZE-1){1'b0}}, 1'b1});
    assign w_any_hit = |w_hit;
    assign w_full    = w_valid[PALETTE_SIZE-1];
    assign w_ovf_new = r_ovf || (!w_any_hit && w_full);
    assign w_pick    = w_any_hit ? w_first : w_alloc_vec;

    always_comb begin
        w_idx = '0;
        for (int i = 0; i < PALETTE_SIZE; i++) begin
            if (w_pick[i]) begin
                w_idx = w_idx | IDX_W'(i);
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_PIXEL: begin
                if (w_proc && r_p_last && !w_ovf_new) begin
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (w_rep_take && !w_valid[1]) begin
                    n_state = ST_PIXEL;
                end
            end
            default: n_state = ST_PIXEL;
        endcase
    end

    // State outputs
    always_comb begin
        w_out_free     = !r_o_valid || !i_out_stall;
        w_proc         = 1'b0;
        w_rep_take     = 1'b0;
        case (r_state)
            ST_PIXEL:  w_proc     = r_p_valid && w_out_free;
            ST_REPORT: w_rep_take = w_out_free;
            default: begin
                w_proc     = 1'b0;
                w_rep_take = 1'b0;
            end
        endcase
        w_ctl.clear    = w_proc && r_p_last && w_ovf_new;
        w_ctl.shift    = w_rep_take;
        w_ctl.update   = w_proc && !w_ovf_new;
        w_ctl.alloc_en = w_proc && !w_ovf_new && !w_any_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_PIXEL;
            r_ovf     <= 1'b0;
            r_rep_idx <= '0;
        end else begin
            r_state <= n_state;
            if (w_proc) begin
                // drop the flag at the tile boundary
                r_ovf     <= r_p_last ? 1'b0 : w_ovf_new;
                r_rep_idx <= '0;
            end else if (w_rep_take) begin
                r_rep_idx <= r_rep_idx + IDX_W'(1);
            end
        end
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (w_proc || w_rep_take) begin
            n_o_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_o_kind <= KIND_PIXEL;
            r_o_idx  <= w_ovf_new ? '0 : w_idx;
            r_o_ovf  <= w_ovf_new;
            r_o_cnt  <= '0;
            r_o_sy   <= '0;
            r_o_su   <= '0;
            r_o_sv   <= '0;
            r_o_fin  <= !(r_p_last && !w_ovf_new);
        end else if (w_rep_take) begin
            r_o_kind <= KIND_REPORT;
            r_o_idx  <= r_rep_idx;
            r_o_ovf  <= 1'b0;
            r_o_cnt  <= w_ent[0].count;
            r_o_sy   <= w_ent[0].sum_y;
            r_o_su   <= w_ent[0].sum_u;
            r_o_sv   <= w_ent[0].sum_v;
            r_o_fin  <= !w_valid[1];
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_item_kind    = r_o_kind;
    assign o_entry_index  = r_o_idx;
    assign o_overflowed   = r_o_ovf;
    assign o_pixel_count  = r_o_cnt;
    assign o_sum_luma     = r_o_sy;
    assign o_sum_chroma_u = r_o_su;
    assign o_sum_chroma_v = r_o_sv;
    assign o_final_result = r_o_fin;

    // Used cells always form an unbroken run from the head of the chain
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & ~{w_valid[PALETTE_SIZE-2:0], 1'b1}) == '0)
        else $error("palette cells not contiguous");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> w_full)
        else $error("overflow flagged with free palette cells");

    a_report_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REPORT) |-> w_valid[0])
        else $error("palette drain with empty chain head");

endmodule

`default_nettype wire

@@ bench/tile_palette_builder_unit_tb.sv @@
// Self-checking bench for tile_palette_builder_unit: pixel requests in, index and palette
// reports out, matched against a palette predictor kept in lockstep with accepted requests.
// Depends on tpb_pkg and tile_palette_builder_unit.
`default_nettype none

module tile_palette_builder_unit_tb;
    import tpb_pkg::*;

    localparam int PAL_ENTRIES   = 16;
    localparam int RANDOM_PIXELS = 240;
    localparam int LONG_TILE_LEN = 130;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              eot;
        logic              typed;
        logic [IDX_W-1:0]  exp_index;
        logic              exp_ovf;
        logic              exp_final;
    } t_pixel_row;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  index;
        logic              ovf;
        logic [CNT_W-1:0]  count;
        logic [SUM_W-1:0]  sum_y;
        logic [SUM_W-1:0]  sum_u;
        logic [SUM_W-1:0]  sum_v;
        logic              fin;
    } t_palette_result;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [DEPTH_W-1:0] cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [COMP_W-1:0]  pix_red = '0;
    logic [COMP_W-1:0]  pix_green = '0;
    logic [COMP_W-1:0]  pix_blue = '0;
    logic               pix_eot = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               res_kind;
    logic [IDX_W-1:0]   res_index;
    logic               res_ovf;
    logic [CNT_W-1:0]   res_count;
    logic [SUM_W-1:0]   res_sum_y;
    logic [SUM_W-1:0]   res_sum_u;
    logic [SUM_W-1:0]   res_sum_v;
    logic               res_final;

    // palette predictor state
    logic [KEY_W-1:0]   pal_key   [PAL_ENTRIES];
    logic [CNT_W-1:0]   pal_count [PAL_ENTRIES];
    logic [SUM_W-1:0]   pal_sum_y [PAL_ENTRIES];
    logic [SUM_W-1:0]   pal_sum_u [PAL_ENTRIES];
    logic [SUM_W-1:0]   pal_sum_v [PAL_ENTRIES];
    int                 pal_used;
    logic               pal_overflow;
    logic [DEPTH_W-1:0] pal_depth;

    t_palette_result    palette_results_due[$];
    t_pixel_row         directed_rows[$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    int                 random_pixels_sent = 0;
    int                 stall_left = 0;
    int                 calm_left = 0;
    bit                 sender_calm = 1'b0;
    bit                 paused_once = 1'b0;

    tile_palette_builder_unit #(
        .PALETTE_SIZE(PAL_ENTRIES)
    ) u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_pixel_red    (pix_red),
        .i_pixel_green  (pix_green),
        .i_pixel_blue   (pix_blue),
        .i_end_of_tile  (pix_eot),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_item_kind    (res_kind),
        .o_entry_index  (res_index),
        .o_overflowed   (res_ovf),
        .o_pixel_count  (res_count),
        .o_sum_luma     (res_sum_y),
        .o_sum_chroma_u (res_sum_u),
        .o_sum_chroma_v (res_sum_v),
        .o_final_result (res_final)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL tile_palette_builder_unit");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch %s: got %0d expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    function automatic int clip(input int value, input int limit);
        return (value > limit) ? limit : value;
    endfunction

    function automatic void clear_palette();
        for (int i = 0; i < PAL_ENTRIES; i++) begin
            pal_key[i]   = '0;
            pal_count[i] = '0;
            pal_sum_y[i] = '0;
            pal_sum_u[i] = '0;
            pal_sum_v[i] = '0;
        end
        pal_used     = 0;
        pal_overflow = 1'b0;
    endfunction

    // Match one accepted pixel against the palette and queue the results it causes.
    function automatic void predict_palette(input t_pixel_row px);
        int               luma;
        int               cu;
        int               cv;
        int               keep;
        int               k;
        int               slot;
        logic [COMP_W-1:0] comp_mask;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] mask;
        bit               gives_reports;
        t_palette_result  res;
        luma = (int'(px.red) + 2 * int'(px.green) + int'(px.blue)) >> 2;
        cu   = (int'(px.blue) + 255 - luma) >> 1;
        cv   = (int'(px.red) + 255 - luma) >> 1;
        key  = {luma[7:0], cu[7:0], cv[7:0]};
        keep = (pal_depth > DEPTH_MAX) ? 8 : int'(pal_depth);
        comp_mask = 8'hFF << (8 - keep);
        mask = {3{comp_mask}};
        slot = 0;
        if (!pal_overflow) begin
            k = 0;
            while (k < pal_used && (pal_key[k] & mask) != (key & mask))
                k++;
            if (k == pal_used) begin
                if (pal_used >= PAL_ENTRIES) begin
                    pal_overflow = 1'b1;
                end else begin
                    pal_key[k] = key;
                    pal_used++;
                end
            end
            if (!pal_overflow) begin
                pal_count[k] = CNT_W'(clip(int'(pal_count[k]) + 1, int'(CNT_MAX)));
                pal_sum_y[k] = SUM_W'(clip(int'(pal_sum_y[k]) + luma, int'(SUM_MAX)));
                pal_sum_u[k] = SUM_W'(clip(int'(pal_sum_u[k]) + cu, int'(SUM_MAX)));
                pal_sum_v[k] = SUM_W'(clip(int'(pal_sum_v[k]) + cv, int'(SUM_MAX)));
                slot = k;
            end
        end
        gives_reports = px.eot && !pal_overflow && pal_used > 0;
        res = '0;
        res.kind  = KIND_PIXEL;
        res.index = slot[IDX_W-1:0];
        res.ovf   = pal_overflow;
        res.fin   = !gives_reports;
        palette_results_due.push_back(res);
        if (gives_reports) begin
            for (int e = 0; e < pal_used; e++) begin
                res.kind  = KIND_REPORT;
                res.index = e[IDX_W-1:0];
                res.ovf   = 1'b0;
                res.count = pal_count[e];
                res.sum_y = pal_sum_y[e];
                res.sum_u = pal_sum_u[e];
                res.sum_v = pal_sum_v[e];
                res.fin   = (e + 1 == pal_used);
                palette_results_due.push_back(res);
            end
        end
        if (px.eot)
            clear_palette();
    endfunction

    function automatic t_pixel_row make_row(input int r, input int g, input int b,
                                            input bit eot, input bit typed,
                                            input int idx, input bit ovf, input bit fin);
        t_pixel_row row;
        row.red       = r[7:0];
        row.green     = g[7:0];
        row.blue      = b[7:0];
        row.eot       = eot;
        row.typed     = typed;
        row.exp_index = idx[IDX_W-1:0];
        row.exp_ovf   = ovf;
        row.exp_final = fin;
        return row;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_calm || roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    // Present one request, hold it until accepted, then update the prediction.
    task automatic send_pixel(input t_pixel_row row);
        int gap;
        int base;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        pix_red   <= row.red;
        pix_green <= row.green;
        pix_blue  <= row.blue;
        pix_eot   <= row.eot;
        do @(posedge clk); while (in_stall);
        base = palette_results_due.size();
        predict_palette(row);
        if (row.typed) begin
            palette_results_due[base].index = row.exp_index;
            palette_results_due[base].ovf   = row.exp_ovf;
            palette_results_due[base].fin   = row.exp_final;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (palette_results_due.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_depth(input int depth);
        wait_idle();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= depth[DEPTH_W-1:0];
        @(posedge clk);
        pal_depth = depth[DEPTH_W-1:0];
        cfg_we <= 1'b0;
    endtask

    // One tile of random content: kind 0 normal, 1 overflow, 2 open (no end),
    // 3 noise, 4 long tile that drives counts and sums into saturation.
    task automatic run_tile(input int kind);
        logic [23:0] pool[$];
        int          len;
        int          colors;
        logic [23:0] rgb;
        t_pixel_row  row;
        case (kind)
            1: begin
                len = $urandom_range(18, 30);
                colors = $urandom_range(17, 24);
            end
            3: begin
                len = $urandom_range(1, 20);
                colors = 0;
            end
            4: begin
                len = LONG_TILE_LEN;
                colors = $urandom_range(1, 3);
                pool.push_back(24'hFFFFFF);
            end
            default: begin
                len = $urandom_range(1, 24);
                colors = $urandom_range(1, 12);
            end
        endcase
        repeat (colors) pool.push_back(24'($urandom()));
        for (int i = 0; i < len; i++) begin
            if (pool.size() > 0 && $urandom_range(0, 99) < 85)
                rgb = pool[$urandom_range(0, pool.size() - 1)];
            else
                rgb = 24'($urandom());
            row = make_row(rgb[23:16], rgb[15:8], rgb[7:0],
                           (i == len - 1) && kind != 2, 1'b0, 0, 1'b0, 1'b0);
            send_pixel(row);
            random_pixels_sent++;
            // hold the sender once until the block has drained
            if (!paused_once && random_pixels_sent > 60) begin
                wait_idle();
                paused_once = 1'b1;
            end
        end
    endtask

    always @(posedge clk) begin : stall_pattern
        int roll;
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (calm_left > 0) begin
            out_stall <= 1'b0;
            calm_left <= calm_left - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
                out_stall <= 1'b0;
                calm_left <= $urandom_range(0, 3);
            end else if (roll < 85) begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else if (roll < 93) begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(8, 20);
            end else begin
                out_stall <= 1'b0;
                calm_left <= $urandom_range(30, 80);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_palette_result want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (palette_results_due.size() == 0) begin
                report_mismatch("result with nothing due, entry_index", res_index, 0);
            end else begin
                want = palette_results_due.pop_front();
                if (res_kind !== want.kind)
                    report_mismatch("item_kind", res_kind, int'(want.kind));
                if (res_index !== want.index)
                    report_mismatch("entry_index", res_index, want.index);
                if (res_ovf !== want.ovf)
                    report_mismatch("overflowed", res_ovf, want.ovf);
                if (res_count !== want.count)
                    report_mismatch("pixel_count", res_count, want.count);
                if (res_sum_y !== want.sum_y)
                    report_mismatch("sum_luma", res_sum_y, want.sum_y);
                if (res_sum_u !== want.sum_u)
                    report_mismatch("sum_chroma_u", res_sum_u, want.sum_u);
                if (res_sum_v !== want.sum_v)
                    report_mismatch("sum_chroma_v", res_sum_v, want.sum_v);
                if (res_final !== want.fin)
                    report_mismatch("final_result", res_final, want.fin);
            end
        end
    end

    initial begin : stimulus
        int depth_plan[12];
        int phase;
        int roll;
        int kind;
        depth_plan = '{0, 15, 3, 8, 1, 9, 6, 8, 2, 4, 7, 8};
        pal_depth = DEPTH_MAX;
        clear_palette();

        // first tile: black, white, primaries; then a tile that overflows
        directed_rows.push_back(make_row(0, 0, 0, 0, 1, 0, 0, 1));
        directed_rows.push_back(make_row(255, 255, 255, 0, 1, 1, 0, 1));
        directed_rows.push_back(make_row(0, 0, 0, 0, 1, 0, 0, 1));
        directed_rows.push_back(make_row(255, 0, 0, 0, 1, 2, 0, 1));
        directed_rows.push_back(make_row(0, 255, 0, 0, 1, 3, 0, 1));
        directed_rows.push_back(make_row(0, 0, 255, 0, 1, 4, 0, 1));
        directed_rows.push_back(make_row(255, 255, 255, 1, 1, 1, 0, 0));
        for (int k = 0; k < PAL_ENTRIES; k++)
            directed_rows.push_back(make_row(16 * k, 16 * k, 16 * k, 0, 1, k, 0, 1));
        directed_rows.push_back(make_row(1, 2, 3, 0, 1, 0, 1, 1));
        directed_rows.push_back(make_row(0, 0, 0, 1, 1, 0, 1, 1));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_pixel(directed_rows[i]);

        phase = 0;
        while (random_pixels_sent < RANDOM_PIXELS) begin
            write_depth(depth_plan[phase % 12]);
            sender_calm = ($urandom_range(0, 3) == 0);
            if (phase == 0)
                run_tile(4);
            repeat ($urandom_range(1, 3)) begin
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    kind = 1;
                else if (roll < 22)
                    kind = 2;
                else if (roll < 30)
                    kind = 3;
                else
                    kind = 0;
                run_tile(kind);
            end
            phase++;
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS tile_palette_builder_unit");
        else
            $display("FAIL tile_palette_builder_unit");
        $finish;
    end

endmodule

`default_nettype wire
